>>> rtl/core/ilst_pkg.sv
// ============================================================================
// ilst_pkg
// Shared types and constants of the indexed list store: request and status
// codes, and the command word that travels from the front end to the back end.
// ============================================================================
package ilst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam int ACT_W    = 2;
    localparam int POS_W    = 4;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // request codes
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // work the back end has to do for one request
    typedef enum logic [2:0] {
        OP_FAIL   = 3'd0,
        OP_READ   = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op                    op;
        logic [POS_W-1:0]           pos;
        logic signed [WORD_W-1:0]   word;
        logic [STATUS_W-1:0]        status;
        logic [COUNT_W-1:0]         entry_count;
        logic                       is_empty;
    } t_cmd;

endpackage

>>> rtl/core/ilst_ifs.sv
// ============================================================================
// ilst_ifs
// Valid/ready channels of the indexed list store: request and response.
// ============================================================================
interface ilst_req_if;
    logic                                       valid;
    logic                                       ready;
    logic [ilst_pkg::ACT_W-1:0]                 action;
    logic [ilst_pkg::POS_W-1:0]                 position;
    logic signed [ilst_pkg::WORD_W-1:0]         word_in;

    modport source (output valid, action, position, word_in, input ready);
    modport sink   (input valid, action, position, word_in, output ready);
endinterface

interface ilst_rsp_if;
    logic                                       valid;
    logic                                       ready;
    logic [ilst_pkg::STATUS_W-1:0]              status;
    logic signed [ilst_pkg::WORD_W-1:0]         word_out;
    logic [ilst_pkg::COUNT_W-1:0]               entry_count;
    logic                                       is_empty;

    modport source (output valid, status, word_out, entry_count, is_empty, input ready);
    modport sink   (input valid, status, word_out, entry_count, is_empty, output ready);
endinterface

>>> rtl/core/ilst_front.sv
// ============================================================================
// ilst_front
// Request front end: tracks the list length, checks each request against it
// and turns it into a command with its status and resulting count.
// ============================================================================
module ilst_front #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ilst_req_if.sink        i_req,
    output logic            o_push,
    output ilst_pkg::t_cmd  o_cmd,
    input  logic            i_full
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ilst_pkg::POS_W) ? CW : ilst_pkg::POS_W;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CMPW-1:0] cnt_c;
    logic [CMPW-1:0] pos_c;
    logic            list_full;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        cnt_c     = CMPW'(r_count);
        pos_c     = CMPW'(i_req.position);
        list_full = (r_count == CW'(CAPACITY));
        n_count   = r_count;
        o_cmd.op     = ilst_pkg::OP_FAIL;
        o_cmd.status = ilst_pkg::ST_OK;
        case (i_req.action)
            ilst_pkg::ACT_READ: begin
                if (r_count == '0) begin
                    o_cmd.status = ilst_pkg::ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    o_cmd.status = ilst_pkg::ST_BOUNDS;
                end else begin
                    o_cmd.op = ilst_pkg::OP_READ;
                end
            end
            ilst_pkg::ACT_APPEND: begin
                if (list_full) begin
                    o_cmd.status = ilst_pkg::ST_FULL;
                end else begin
                    o_cmd.op = ilst_pkg::OP_APPEND;
                    n_count  = r_count + 1'b1;
                end
            end
            ilst_pkg::ACT_INSERT: begin
                if (pos_c > cnt_c) begin
                    o_cmd.status = ilst_pkg::ST_BOUNDS;
                end else if (list_full) begin
                    o_cmd.status = ilst_pkg::ST_FULL;
                end else begin
                    o_cmd.op = ilst_pkg::OP_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            default: begin
                if (pos_c >= cnt_c) begin
                    o_cmd.status = ilst_pkg::ST_BOUNDS;
                end else begin
                    o_cmd.op = ilst_pkg::OP_REMOVE;
                    n_count  = r_count - 1'b1;
                end
            end
        endcase
        o_cmd.pos         = i_req.position;
        o_cmd.word        = i_req.word_in;
        o_cmd.entry_count = ilst_pkg::COUNT_W'(n_count);
        o_cmd.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/ilst_fifo.sv
// ============================================================================
// ilst_fifo
// Short command queue between front end and back end.
// ============================================================================
module ilst_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ilst_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output ilst_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    localparam int QD  = ilst_pkg::QUEUE_DEPTH;
    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    ilst_pkg::t_cmd r_slot [QD];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_fill;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_fill == QCW'(QD));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/ilst_back.sv
// ============================================================================
// ilst_back
// Command back end: owns the word memory, moves words one per cycle for
// insert and remove, and holds the response register.
// ============================================================================
module ilst_back #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ilst_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    ilst_rsp_if.source      o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int WW = ilst_pkg::WORD_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PUT   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    logic [WW-1:0]  r_mem [CAPACITY];
    logic [WW-1:0]  r_rd;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    ilst_pkg::t_cmd r_cmd, n_cmd;
    logic [AW-1:0]  r_ra, n_ra;
    logic [AW-1:0]  r_end, n_end;
    logic           r_pv, n_pv;
    logic [AW-1:0]  r_pwa, n_pwa;
    logic           r_pcap, n_pcap;
    logic [WW-1:0]  r_res_word, n_res_word;
    logic           r_ov, n_ov;
    ilst_pkg::t_cmd r_out, n_out;
    logic [WW-1:0]  r_out_word, n_out_word;

    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [WW-1:0]  mem_wd;
    logic [AW-1:0]  mem_ra;
    logic [AW-1:0]  pos_in;
    logic [AW-1:0]  pos_r;
    logic [AW-1:0]  cnt_m1;

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.word_out    = r_out_word;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.is_empty    = r_out.is_empty;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_ra       = r_ra;
        n_end      = r_end;
        n_pv       = 1'b0;
        n_pwa      = r_pwa;
        n_pcap     = r_pcap;
        n_res_word = r_res_word;
        n_ov       = r_ov;
        n_out      = r_out;
        n_out_word = r_out_word;
        o_pop      = 1'b0;
        pos_in     = AW'(i_cmd.pos);
        pos_r      = AW'(r_cmd.pos);
        cnt_m1     = AW'(r_cnt - 1'b1);
        mem_we     = 1'b0;
        mem_wa     = r_pwa;
        mem_wd     = r_rd;
        mem_ra     = r_ra;

        // retire the word read last cycle: keep it as result or move it
        if (r_pv) begin
            if (r_pcap) begin
                n_res_word = r_rd;
            end else begin
                mem_we = 1'b1;
            end
        end

        if (o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_cmd;
                    n_res_word = '0;
                    case (i_cmd.op)
                        ilst_pkg::OP_READ: begin
                            mem_ra  = pos_in;
                            n_pv    = 1'b1;
                            n_pcap  = 1'b1;
                            n_state = S_DRAIN;
                        end
                        ilst_pkg::OP_APPEND: begin
                            mem_we  = 1'b1;
                            mem_wa  = AW'(r_cnt);
                            mem_wd  = i_cmd.word;
                            n_cnt   = r_cnt + 1'b1;
                            n_state = S_FIN;
                        end
                        ilst_pkg::OP_INSERT: begin
                            n_cnt = r_cnt + 1'b1;
                            if (AW'(r_cnt) == pos_in) begin
                                n_state = S_PUT;
                            end else begin
                                n_ra    = cnt_m1;
                                n_end   = pos_in;
                                n_state = S_SHIFT;
                            end
                        end
                        ilst_pkg::OP_REMOVE: begin
                            n_cnt   = r_cnt - 1'b1;
                            n_ra    = pos_in;
                            n_end   = cnt_m1;
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                mem_ra = r_ra;
                n_pv   = 1'b1;
                if (r_cmd.op == ilst_pkg::OP_INSERT) begin
                    n_pwa  = AW'(r_ra + 1'b1);
                    n_pcap = 1'b0;
                end else begin
                    n_pwa  = AW'(r_ra - 1'b1);
                    n_pcap = (r_ra == pos_r);
                end
                if (r_ra == r_end) begin
                    n_state = S_DRAIN;
                end else if (r_cmd.op == ilst_pkg::OP_INSERT) begin
                    n_ra = AW'(r_ra - 1'b1);
                end else begin
                    n_ra = AW'(r_ra + 1'b1);
                end
            end
            S_DRAIN: begin
                n_state = (r_cmd.op == ilst_pkg::OP_INSERT) ? S_PUT : S_FIN;
            end
            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = pos_r;
                mem_wd  = r_cmd.word;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_out      = r_cmd;
                    n_out_word = r_res_word;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ra       <= n_ra;
        r_end      <= n_end;
        r_pwa      <= n_pwa;
        r_pcap     <= n_pcap;
        r_res_word <= n_res_word;
        r_out      <= n_out;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

endmodule

>>> rtl/core/indexed_list_store_core.sv
// ============================================================================
// indexed_list_store_core
// Bounded ordered list of signed 32-bit words with read, append, insert and
// remove by position.
// ============================================================================
// Usage:
//   i_req carries one request per transaction (action, position, word_in);
//   o_rsp returns exactly one response per request, in order (status,
//   word_out, entry_count, is_empty). Both are valid/ready channels.
//   The front end checks each request against its own copy of the length,
//   so the status and count are known at once; it then queues a command
//   for the back end, which owns the word memory.
//   In the back end a failed request only gets its response, an append
//   writes at the end, a read fetches one word, a remove returns the word
//   at the position and moves each later word down, and an insert moves
//   each word from the position on up, then writes the new word. One word
//   moves per cycle because the memory has one read and one write port.
//   Reset empties the list at once; the words themselves are not cleared
//   and need no clearing pass, since only filled positions are ever read.
//   When o_rsp stalls, the response register holds; the queue still takes
//   requests until it is full, then i_req.ready drops.
// ============================================================================
module indexed_list_store_core #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilst_req_if.sink    i_req,
    ilst_rsp_if.source  o_rsp
);

    // front end -> queue
    logic            front_push;
    ilst_pkg::t_cmd  front_cmd;
    logic            queue_full;

    // queue -> back end
    logic            queue_valid;
    ilst_pkg::t_cmd  queue_cmd;
    logic            back_pop;

    // classify requests and keep the running length
    ilst_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_push  (front_push),
        .o_cmd   (front_cmd),
        .i_full  (queue_full)
    );

    // decouple front and back so each can stall on its own
    ilst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (back_pop)
    );

    // carry out memory work and drive the response
    ilst_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_cmd   (queue_cmd),
        .o_pop   (back_pop),
        .o_rsp   (o_rsp)
    );

endmodule

>>> bench/ilst_list_checker.sv
// ============================================================================
// ilst_list_checker
// Watches the request and response channels of the indexed list store.
// Keeps its own copy of the list, predicts each response and compares the
// responses in order.
// ============================================================================
module ilst_list_checker #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ilst_req_if                         i_req,
    ilst_rsp_if                         i_rsp,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output logic [ilst_pkg::COUNT_W-1:0] o_list_count
);
    import ilst_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]         entry_count;
        logic                       is_empty;
    } t_list_result;

    localparam int REPORT_LIMIT = 10;

    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_count;
    t_list_result             expected_results [$];

    // Update the shadow list for one request and return its response.
    function automatic t_list_result apply_request(
        input logic [ACT_W-1:0]         act,
        input logic [POS_W-1:0]         pos,
        input logic signed [WORD_W-1:0] w
    );
        t_list_result r;
        int           i;
        r.status = ST_OK;
        r.word   = '0;
        case (act)
            ACT_READ: begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else if (int'(pos) >= list_count)
                    r.status = ST_BOUNDS;
                else
                    r.word = list_words[pos];
            end
            ACT_APPEND: begin
                if (list_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_count] = w;
                    list_count++;
                end
            end
            ACT_INSERT: begin
                if (int'(pos) > list_count) begin
                    r.status = ST_BOUNDS;
                end else if (list_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_count; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = w;
                    list_count++;
                end
            end
            default: begin
                if (int'(pos) >= list_count) begin
                    r.status = ST_BOUNDS;
                end else begin
                    r.word = list_words[pos];
                    for (i = int'(pos); i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                end
            end
        endcase
        r.entry_count = COUNT_W'(list_count);
        r.is_empty    = (list_count == 0);
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
        o_list_count = '0;
        list_count   = 0;
    end

    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            list_count = 0;
            expected_results.delete();
        end else begin
            // compare first: a response never answers a request of the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                got.status      = i_rsp.status;
                got.word        = i_rsp.word_out;
                got.entry_count = i_rsp.entry_count;
                got.is_empty    = i_rsp.is_empty;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("[%0t] unexpected: status %0d word %0d count %0d empty %0b",
                                 $realtime, got.status, got.word, got.entry_count, got.is_empty);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (got.status !== want.status || got.word !== want.word ||
                        got.entry_count !== want.entry_count ||
                        got.is_empty !== want.is_empty) begin
                        if (o_fail_count < REPORT_LIMIT) begin
                            $write("[%0t] response %0d mismatch: status %0d/%0d ",
                                   $realtime, o_checked, want.status, got.status);
                            $display("word %0d/%0d count %0d/%0d empty %0b/%0b (exp/act)",
                                     want.word, got.word, want.entry_count, got.entry_count,
                                     want.is_empty, got.is_empty);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                expected_results.push_back(
                    apply_request(i_req.action, i_req.position, i_req.word_in));
        end
        o_pending    = expected_results.size();
        o_list_count = COUNT_W'(list_count);
    end

endmodule

>>> bench/tb_indexed_list_store_core.sv
// ============================================================================
// tb_indexed_list_store_core
// Drives read, append, insert and remove requests into the indexed list
// store: a directed pass over empty, full and out-of-range cases, then
// phased random traffic that grows and drains the list, with random gaps on
// the request side and random stalls on the response side. A checker beside
// the block predicts every response.
// ============================================================================
module tb_indexed_list_store_core;
    import ilst_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int N_RANDOM     = 1100;
    localparam int PHASE_LEN    = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilst_req_if req_if ();
    ilst_rsp_if rsp_if ();

    int                 fail_count;
    int                 pending;
    int                 checked;
    logic [COUNT_W-1:0] list_count;

    int cycles        = 0;
    int items_sent    = 0;
    int n_directed    = 0;
    int n_phases      = 0;
    int req_gap_pct   = 0;   // chance of a gap before each request
    int rsp_stall_pct = 0;   // chance of starting a stall on each idle cycle
    int add_pct       = 50;  // share of appends and inserts among writes

    indexed_list_store_core #(.CAPACITY(CAPACITY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ilst_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_list_count (list_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short idles, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // Response side: drop ready for random stretches; zero chance means no stalls.
    initial begin
        int hold;
        hold = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                rsp_if.ready = 1'b0;
                hold--;
            end else begin
                rsp_if.ready = 1'b1;
                if (int'($urandom_range(99)) < rsp_stall_pct)
                    hold = pick_gap();
            end
        end
    end

    // Present one request at a falling edge and hold it until accepted.
    // Return at the falling edge after the transaction.
    task automatic send_request(
        input logic [ACT_W-1:0]         act,
        input logic [POS_W-1:0]         pos,
        input logic signed [WORD_W-1:0] w
    );
        int gap;
        gap = (int'($urandom_range(99)) < req_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) begin
                // scramble the idle payload, it must be ignored
                req_if.action   = ACT_W'($urandom);
                req_if.position = POS_W'($urandom);
                req_if.word_in  = $urandom;
                @(negedge i_clk);
            end
        end
        req_if.valid    = 1'b1;
        req_if.action   = act;
        req_if.position = pos;
        req_if.word_in  = w;
        do @(posedge i_clk); while (!req_if.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Build one random request. Positions mostly land in 0..count so that
    // inserts and removes actually shift words; the rest are anywhere.
    task automatic send_random_request();
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] w;
        int                       n;
        n = int'(list_count);
        if ($urandom_range(99) < 15)
            act = ACT_READ;
        else if (int'($urandom_range(99)) < add_pct)
            act = $urandom_range(1) ? ACT_APPEND : ACT_INSERT;
        else
            act = ACT_REMOVE;
        if ($urandom_range(9) < 8)
            pos = POS_W'($urandom_range((n > 15) ? 15 : n));
        else
            pos = POS_W'($urandom_range(15));
        case ($urandom_range(9))
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7fff_ffff;
            2:       w = $urandom_range(1) ? 32'sh0 : -32'sh1;
            default: w = $urandom;
        endcase
        send_request(act, pos, w);
    endtask

    initial begin
        int k;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.action   = ACT_READ;
        req_if.position = '0;
        req_if.word_in  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty list, bounds, appends until full, full rejects,
        // then removal at both ends.
        send_request(ACT_READ,   4'd0,  32'sh0);          // read of empty list
        send_request(ACT_REMOVE, 4'd0,  32'sh0);          // remove from empty list
        send_request(ACT_INSERT, 4'd1,  32'sh1234_5678);  // insert past the end
        send_request(ACT_INSERT, 4'd0,  32'sh8000_0000);  // insert at count appends
        send_request(ACT_APPEND, 4'd15, 32'sh7fff_ffff);  // position ignored
        send_request(ACT_READ,   4'd1,  -32'sh1);         // word_in ignored
        send_request(ACT_READ,   4'd2,  32'sh0);          // read at count
        for (k = 0; k < CAPACITY - 2; k++)
            send_request(ACT_APPEND, POS_W'(k), $urandom);
        send_request(ACT_APPEND, 4'd0,  32'sh5555_5555);  // append to full list
        send_request(ACT_INSERT, 4'd5,  -32'sh2);         // insert into full list
        send_request(ACT_REMOVE, 4'd15, 32'sh0);          // remove last word
        send_request(ACT_REMOVE, 4'd0,  32'sh0);          // remove first word
        n_directed = items_sent;

        // Random: each phase picks growth, drain or balance at random, with idling
        // that ranges from none to heavy on each side.
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % PHASE_LEN == 0) begin
                n_phases++;
                case ($urandom_range(4))
                    0: add_pct = 85;
                    1: add_pct = 15;
                    2: add_pct = 50;
                    3: add_pct = 97;
                    default: add_pct = 3;
                endcase
                case ($urandom_range(3))
                    0: req_gap_pct = 0;
                    1: req_gap_pct = 10;
                    2: req_gap_pct = 30;
                    default: req_gap_pct = 60;
                endcase
                case ($urandom_range(3))
                    0: rsp_stall_pct = 0;
                    1: rsp_stall_pct = 10;
                    2: rsp_stall_pct = 30;
                    default: rsp_stall_pct = 60;
                endcase
            end
            send_random_request();
        end
        req_if.valid = 1'b0;

        // Drain outstanding responses, then give stray ones a chance to show.
        while (pending != 0)
            @(negedge i_clk);
        rsp_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("drove %0d requests: %0d directed, %0d random over %0d traffic phases",
                 items_sent, n_directed, items_sent - n_directed, n_phases);
        $display("checked %0d responses in %0d cycles, %0d mismatches",
                 checked, cycles, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
